// ===== hw/rtl/itp_pkg.sv =====
// itp_pkg: shared constants, history type and elaboration-time helpers for the
// indirect target predictor. No dependencies.
package itp_pkg;

  localparam int unsigned NUM_TABLES_DEF  = 8;
  localparam int unsigned INDEX_BITS_DEF  = 10;
  localparam int unsigned TAG_BITS_DEF    = 9;
  localparam int unsigned MIN_HISTORY_DEF = 4;
  localparam int unsigned MAX_HISTORY_DEF = 256;

  localparam int unsigned HIST_WORDS  = 16;
  localparam int unsigned DECAY_LIMIT = 500;
  localparam int unsigned LEN_CAP     = 1024;
  // fold step is never below 3, so this covers any history length
  localparam int unsigned FOLD_ITERS  = LEN_CAP / 3 + 1;

  localparam logic [1:0] KIND_PREDICT = 2'd0;
  localparam logic [1:0] KIND_UPDATE  = 2'd1;
  localparam logic [1:0] KIND_PUSH    = 2'd2;
  // ignored, no response
  localparam logic [1:0] KIND_RSVD    = 2'd3;

  localparam logic [3:0] HIT_NONE = 4'hF;

  typedef logic [HIST_WORDS-1:0][63:0] hist_t;

  // rounded geometric history length of table t, exact integer form
  function automatic int unsigned geo_len(int unsigned t, int unsigned nt,
                                          int unsigned minh, int unsigned maxh);
    logic [127:0] rhs;
    logic [127:0] lhs;
    int unsigned  k;
    int unsigned  h;
    logic         done;
    k    = nt - 1;
    rhs  = 128'd1;
    h    = 1;
    done = 1'b0;
    for (int unsigned j = 0; j < k; j++) rhs = rhs * 128'd2;
    for (int unsigned j = 0; j < k - t; j++) rhs = rhs * 128'(minh);
    for (int unsigned j = 0; j < t; j++) rhs = rhs * 128'(maxh);
    for (int unsigned i = 1; i < LEN_CAP; i++) begin
      if (!done) begin
        lhs = 128'd1;
        for (int unsigned j = 0; j < k; j++) lhs = lhs * 128'(2 * i + 1);
        if (lhs > rhs) done = 1'b1;
        else h = i + 1;
      end
    end
    return h;
  endfunction

  // xor-fold the first len history bits in chunks of step bits
  function automatic logic [63:0] fold(hist_t hist, int unsigned len, int unsigned step);
    logic [63:0]  acc;
    logic [63:0]  g;
    int unsigned  h;
    acc = '0;
    for (int unsigned i = 0; i < FOLD_ITERS; i++) begin
      h = i * step;
      if (h < len) begin
        g = hist[4'(h >> 5)] >> 5'(h);
        if (len < h + step) g = g & ((64'd1 << (len - h)) - 64'd1);
        acc = acc ^ g;
      end
    end
    return acc;
  endfunction

endpackage

// ===== hw/rtl/itp_if.sv =====
// itp_if: request and response channel interfaces of the indirect target
// predictor. No dependencies.
interface itp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] pc;
  logic [63:0] actual_target;
  logic        mispredicted;
  logic [15:0] random_bits;
  modport source(output valid, kind, pc, actual_target, mispredicted, random_bits,
                 input ready);
  modport sink(input valid, kind, pc, actual_target, mispredicted, random_bits,
               output ready);
endinterface

interface itp_rsp_if;
  logic              valid;
  logic              ready;
  logic [63:0]       predicted_target;
  logic signed [3:0] hit_table;
  modport source(output valid, predicted_target, hit_table, input ready);
  modport sink(input valid, predicted_target, hit_table, output ready);
endinterface

// ===== hw/rtl/itp_front.sv =====
// itp_front: global target history, per-table index/tag hashing and request
// classification. Depends on itp_pkg and itp_if.
module itp_front #(
  parameter int unsigned NUM_TABLES  = itp_pkg::NUM_TABLES_DEF,
  parameter int unsigned INDEX_BITS  = itp_pkg::INDEX_BITS_DEF,
  parameter int unsigned TAG_BITS    = itp_pkg::TAG_BITS_DEF,
  parameter int unsigned MIN_HISTORY = itp_pkg::MIN_HISTORY_DEF,
  parameter int unsigned MAX_HISTORY = itp_pkg::MAX_HISTORY_DEF,
  parameter int unsigned QW          = 1
) (
  input  logic          clk,
  input  logic          rst,
  itp_req_if.sink       req,
  output logic          q_valid,
  input  logic          q_ready,
  output logic [QW-1:0] q_data
);
  import itp_pkg::*;

  typedef struct packed {
    logic                                 upd;
    logic [NUM_TABLES-1:0][INDEX_BITS-1:0] ix;
    logic [NUM_TABLES-1:0][TAG_BITS-1:0]   tg;
    logic [63:0]                           target;
    logic                                  mispred;
    logic [15:0]                           rnd;
  } qent_t;

  hist_t hist;
  hist_t hist_next;
  logic [NUM_TABLES-1:0][INDEX_BITS-1:0] ix_all;
  logic [NUM_TABLES-1:0][TAG_BITS-1:0]   tg_all;
  qent_t ent;

  for (genvar t = 0; t < NUM_TABLES; t++) begin : g_hash
    localparam int unsigned LEN = geo_len(t, NUM_TABLES, MIN_HISTORY, MAX_HISTORY);
    logic [63:0] ix_full;
    logic [63:0] tg_full;
    always_comb begin
      ix_full = (req.pc >> 2) ^ (req.pc >> (3 + t)) ^ fold(hist, LEN, INDEX_BITS);
      tg_full = (req.pc >> 2) ^ (req.pc << t) ^ fold(hist, LEN, TAG_BITS)
              ^ (fold(hist, LEN, TAG_BITS - 1) << 1);
    end
    assign ix_all[t] = ix_full[INDEX_BITS-1:0];
    assign tg_all[t] = tg_full[TAG_BITS-1:0];
  end

  // bits 33..32 of each shifted word carry into the next one
  always_comb begin
    hist_next[0] = (hist[0] << 2) ^ {56'd0, req.actual_target[9:2]};
    for (int i = 1; i < HIST_WORDS; i++) begin
      hist_next[i] = (hist[i] << 2) ^ {62'd0, hist[i-1][31:30]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (req.valid && req.ready && req.kind == KIND_PUSH) begin
      hist <= hist_next;
    end
  end

  always_comb begin
    ent.upd     = (req.kind == KIND_UPDATE);
    ent.ix      = ix_all;
    ent.tg      = tg_all;
    ent.target  = req.actual_target;
    ent.mispred = req.mispredicted;
    ent.rnd     = req.random_bits;
  end

  assign req.ready = q_ready;
  assign q_valid   = req.valid && (req.kind == KIND_PREDICT || req.kind == KIND_UPDATE);
  assign q_data    = ent;

endmodule

// ===== hw/rtl/itp_queue.sv =====
// itp_queue: two-entry queue between the hashing front and the table back end.
// No dependencies.
module itp_queue #(
  parameter int unsigned W = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  logic [W-1:0] fifo_mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = fifo_mem[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wp] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

// ===== hw/rtl/itp_back.sv =====
// itp_back: tagged entry memory, sequential table probe, training, allocation
// and usefulness decay. Depends on itp_pkg and itp_if.
module itp_back #(
  parameter int unsigned NUM_TABLES = itp_pkg::NUM_TABLES_DEF,
  parameter int unsigned INDEX_BITS = itp_pkg::INDEX_BITS_DEF,
  parameter int unsigned TAG_BITS   = itp_pkg::TAG_BITS_DEF,
  parameter int unsigned QW         = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [QW-1:0] q_data,
  itp_rsp_if.source     rsp
);
  import itp_pkg::*;

  localparam int unsigned TW    = $clog2(NUM_TABLES);
  localparam int unsigned AW    = TW + INDEX_BITS;
  localparam int unsigned DEPTH = NUM_TABLES << INDEX_BITS;
  localparam int unsigned CW    = $clog2(NUM_TABLES + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_RESULT = 3'd3;
  localparam logic [2:0] S_WHIT   = 3'd4;
  localparam logic [2:0] S_WALLOC = 3'd5;
  localparam logic [2:0] S_DECAY  = 3'd6;

  typedef struct packed {
    logic                                  upd;
    logic [NUM_TABLES-1:0][INDEX_BITS-1:0] ix;
    logic [NUM_TABLES-1:0][TAG_BITS-1:0]   tg;
    logic [63:0]                           target;
    logic                                  mispred;
    logic [15:0]                           rnd;
  } qent_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [63:0]         target;
    logic [1:0]          conf;
    logic [1:0]          useful;
  } entry_t;

  entry_t          mem [DEPTH];
  entry_t          rd_data;
  entry_t          wr_data;
  entry_t          hit_new;
  logic            rd_en;
  logic            wr_en;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;

  logic [2:0]      state;
  qent_t           ent;
  qent_t           cur;
  logic [CW-1:0]   cnt;
  logic            chk_v;
  logic [TW-1:0]   chk_t;
  logic            match;

  logic            hv;
  logic [TW-1:0]   bank;
  logic [63:0]     hit_tgt;
  logic [63:0]     alt_tgt;
  logic [1:0]      hit_conf;
  logic [1:0]      hit_use;
  logic [NUM_TABLES-1:0][1:0] use_seen;
  logic            diff;
  logic [63:0]     choice;

  logic signed [3:0] alt_cnt;
  logic signed [3:0] alt_next;
  logic [9:0]      fail;
  logic [9:0]      fail_new;
  logic [10:0]     fsum;
  logic [3:0]      inc;
  logic            found;
  logic [TW-1:0]   at;
  logic            do_alloc;

  logic [AW-1:0]   sp;
  logic            sdone;
  logic            dv;
  logic [AW-1:0]   da;

  logic              o_valid;
  logic [63:0]       o_target;
  logic signed [3:0] o_hit;

  assign ent     = qent_t'(q_data);
  assign q_ready = (state == S_IDLE);
  assign match   = chk_v && (rd_data.tag == cur.tg[chk_t]);
  assign diff    = (hit_tgt != alt_tgt);
  assign choice  = (hit_conf == 2'd0 && !alt_cnt[3]) ? alt_tgt : hit_tgt;
  assign do_alloc = cur.mispred && (hit_tgt != cur.target);

  // first longer table with a nonzero random pair and a free entry
  always_comb begin
    found = 1'b0;
    at    = '0;
    inc   = '0;
    for (int t = 0; t < NUM_TABLES; t++) begin
      if (!found && (!hv || t > int'(bank)) && cur.rnd[2*t +: 2] != 2'b00) begin
        if (use_seen[t] == 2'd0) begin
          found = 1'b1;
          at    = TW'(t);
        end else begin
          inc = inc + 4'd1;
        end
      end
    end
    fsum = {1'b0, fail} + 11'(inc);
    if (found) fail_new = (fsum != 11'd0) ? 10'(fsum - 11'd1) : 10'd0;
    else fail_new = 10'(fsum);
  end

  always_comb begin
    alt_next = alt_cnt;
    if (hv && hit_conf == 2'd0 && diff) begin
      if (alt_tgt == cur.target && alt_cnt != 4'sd7) alt_next = alt_cnt + 4'sd1;
      else if (hit_tgt == cur.target && alt_cnt != -4'sd8) alt_next = alt_cnt - 4'sd1;
    end
  end

  always_comb begin
    hit_new.tag    = cur.tg[bank];
    hit_new.target = hit_tgt;
    hit_new.conf   = hit_conf;
    hit_new.useful = hit_use;
    if (hit_tgt == cur.target) begin
      if (diff && hit_use != 2'd3) hit_new.useful = hit_use + 2'd1;
      if (hit_conf != 2'd3) hit_new.conf = hit_conf + 2'd1;
    end else if (hit_conf != 2'd0) begin
      hit_new.conf = hit_conf - 2'd1;
    end else begin
      hit_new.target = cur.target;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = sp;
    if (state == S_LOOK) begin
      rd_en   = (cnt < CW'(NUM_TABLES));
      rd_addr = {cnt[TW-1:0], cur.ix[cnt[TW-1:0]]};
    end else if (state == S_DECAY) begin
      rd_en = !sdone;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sp;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_WHIT: begin
        wr_en   = hv;
        wr_addr = {bank, cur.ix[bank]};
        wr_data = hit_new;
      end
      S_WALLOC: begin
        wr_en   = 1'b1;
        wr_addr = {at, cur.ix[at]};
        wr_data = '{tag: cur.tg[at], target: cur.target, conf: 2'd0, useful: 2'd0};
      end
      S_DECAY: begin
        wr_en   = dv;
        wr_addr = da;
        wr_data = rd_data;
        if (rd_data.useful != 2'd0) wr_data.useful = rd_data.useful - 2'd1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      sp      <= '0;
      sdone   <= 1'b0;
      dv      <= 1'b0;
      cnt     <= '0;
      chk_v   <= 1'b0;
      hv      <= 1'b0;
      alt_cnt <= '0;
      fail    <= '0;
      o_valid <= 1'b0;
    end else begin
      if (o_valid && rsp.ready && state != S_RESULT) o_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (sp == AW'(DEPTH - 1)) begin
            sp    <= '0;
            state <= S_IDLE;
          end else begin
            sp <= sp + AW'(1);
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur      <= ent;
            cnt      <= '0;
            chk_v    <= 1'b0;
            hv       <= 1'b0;
            bank     <= '0;
            hit_tgt  <= '0;
            alt_tgt  <= '0;
            hit_conf <= '0;
            hit_use  <= '0;
            state    <= S_LOOK;
          end
        end
        S_LOOK: begin
          // read for table cnt goes out while table chk_t is compared
          if (cnt < CW'(NUM_TABLES)) cnt <= cnt + CW'(1);
          chk_v <= (cnt < CW'(NUM_TABLES));
          chk_t <= cnt[TW-1:0];
          if (chk_v) begin
            use_seen[chk_t] <= rd_data.useful;
            if (match) begin
              alt_tgt  <= hit_tgt;
              hit_tgt  <= rd_data.target;
              hit_conf <= rd_data.conf;
              hit_use  <= rd_data.useful;
              bank     <= chk_t;
              hv       <= 1'b1;
            end
            if (chk_t == TW'(NUM_TABLES - 1)) state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!o_valid || rsp.ready) begin
            o_valid  <= 1'b1;
            o_target <= choice;
            o_hit    <= hv ? 4'(bank) : HIT_NONE;
            state    <= cur.upd ? S_WHIT : S_IDLE;
          end
        end
        S_WHIT: begin
          alt_cnt <= alt_next;
          if (do_alloc && found) begin
            fail  <= fail_new;
            state <= S_WALLOC;
          end else if (do_alloc && fail_new > 10'(DECAY_LIMIT)) begin
            fail  <= '0;
            sp    <= '0;
            sdone <= 1'b0;
            dv    <= 1'b0;
            state <= S_DECAY;
          end else begin
            if (do_alloc) fail <= fail_new;
            state <= S_IDLE;
          end
        end
        S_WALLOC: begin
          if (fail > 10'(DECAY_LIMIT)) begin
            fail  <= '0;
            sp    <= '0;
            sdone <= 1'b0;
            dv    <= 1'b0;
            state <= S_DECAY;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DECAY: begin
          if (!sdone) begin
            if (sp == AW'(DEPTH - 1)) sdone <= 1'b1;
            else sp <= sp + AW'(1);
          end
          dv <= !sdone;
          da <= sp;
          if (sdone && !dv) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid            = o_valid;
  assign rsp.predicted_target = o_target;
  assign rsp.hit_table        = o_hit;

endmodule

// ===== hw/rtl/indirect_target_predictor_top.sv =====
// indirect_target_predictor_top: tagged geometric-history indirect target
// predictor. Depends on itp_pkg, itp_if, itp_front, itp_queue, itp_back.
//
// Requests are predict, update or history push; predict and update each return
// one beat with the chosen target and the longest hitting table (-1 if none),
// an update reporting its lookup before training. History pushes are taken one
// per cycle in the front while the queue has room and return nothing.
// Predictions and updates pass through a two-entry queue to the back end, which
// probes one table per cycle on an entry memory with one read and one write
// port: a predict probes every table and then gives its result, and an update
// also trains the hit entry, if any, and may allocate one. After reset the back
// end runs a clearing pass over all NUM_TABLES * 2^INDEX_BITS entries (8192 by
// default) before the first lookup; when allocation failures pass 500 an update
// is followed by a usefulness decay sweep over the same entries.
module indirect_target_predictor_top #(
  parameter int unsigned NUM_TABLES  = itp_pkg::NUM_TABLES_DEF,
  parameter int unsigned INDEX_BITS  = itp_pkg::INDEX_BITS_DEF,
  parameter int unsigned TAG_BITS    = itp_pkg::TAG_BITS_DEF,
  parameter int unsigned MIN_HISTORY = itp_pkg::MIN_HISTORY_DEF,
  parameter int unsigned MAX_HISTORY = itp_pkg::MAX_HISTORY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  itp_req_if.sink   req,
  itp_rsp_if.source rsp
);
  import itp_pkg::*;

  localparam int unsigned QW = 1 + NUM_TABLES * (INDEX_BITS + TAG_BITS) + 64 + 1 + 16;

  logic          f_valid;
  logic          f_ready;
  logic [QW-1:0] f_data;
  logic          b_valid;
  logic          b_ready;
  logic [QW-1:0] b_data;

  itp_front #(
    .NUM_TABLES(NUM_TABLES), .INDEX_BITS(INDEX_BITS), .TAG_BITS(TAG_BITS),
    .MIN_HISTORY(MIN_HISTORY), .MAX_HISTORY(MAX_HISTORY), .QW(QW)
  ) u_front (
    .clk(clk), .rst(rst), .req(req),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  itp_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  itp_back #(
    .NUM_TABLES(NUM_TABLES), .INDEX_BITS(INDEX_BITS), .TAG_BITS(TAG_BITS), .QW(QW)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data), .rsp(rsp)
  );

endmodule

// ===== hw/rtl/itp_checker.sv =====
// itp_checker: port-level assertions on the predictor response channel, bound
// to indirect_target_predictor_top. Depends on itp_if.
module itp_checker #(
  parameter int unsigned NUM_TABLES = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [63:0] rsp_target,
  input logic [3:0]  rsp_hit
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target) && $stable(rsp_hit))
    else $error("response beat changed while stalled");

  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_hit == 4'hF || rsp_hit < 4'(NUM_TABLES)))
    else $error("hit table out of range");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hit == 4'hF |-> rsp_target == 64'd0)
    else $error("nonzero target without a table hit");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response beat right after reset");

endmodule

bind indirect_target_predictor_top itp_checker #(.NUM_TABLES(NUM_TABLES)) u_itp_checker (
  .clk(clk), .rst(rst), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_target(rsp.predicted_target), .rsp_hit(rsp.hit_table)
);
